@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the tap classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/core/tdhc_pkg.sv @@
// Shared types and constants of the tap / double-tap / hold classifier.
package tdhc_pkg;

  localparam int unsigned TsW   = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [1:0] REG_HOLD   = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  localparam logic [CfgW-1:0] HOLD_RST   = 16'd300;
  localparam logic [CfgW-1:0] WINDOW_RST = 16'd250;
  localparam logic [CfgW-1:0] PERIOD_RST = 16'd150;

  localparam logic DIR_LEFT  = 1'b0;
  localparam logic DIR_RIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST_PRESS,
    ST_WAIT_SECOND,
    ST_LEFT_REPEAT,
    ST_RIGHT_REPEAT
  } gesture_e;

  typedef struct packed {
    logic [CfgW-1:0] hold_threshold_ms;
    logic [CfgW-1:0] tap_gap_ms;
    logic [CfgW-1:0] repeat_period_ms;
  } cfg_t;

endpackage

@@ rtl/core/tdhc_cfg.sv @@
// Configuration register file with APB-style access.
module tdhc_cfg
  import tdhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_threshold_ms <= HOLD_RST;
      cfg_q.tap_gap_ms        <= WINDOW_RST;
      cfg_q.repeat_period_ms  <= PERIOD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HOLD:   cfg_q.hold_threshold_ms <= pwdata[CfgW-1:0];
        REG_WINDOW: cfg_q.tap_gap_ms        <= pwdata[CfgW-1:0];
        REG_PERIOD: cfg_q.repeat_period_ms  <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_HOLD:   prdata = {{(DataW-CfgW){1'b0}}, cfg_q.hold_threshold_ms};
      REG_WINDOW: prdata = {{(DataW-CfgW){1'b0}}, cfg_q.tap_gap_ms};
      REG_PERIOD: prdata = {{(DataW-CfgW){1'b0}}, cfg_q.repeat_period_ms};
      default:    prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/tap_doubletap_hold_classifier.sv @@
// Top level: button gesture classifier emitting left/right commands.
// Each input transfer is one poll sample (button level, ms timestamp); it is
// registered, then classified by a gesture state machine whose result goes to
// an output register. One sample is taken every cycle unless a command stalls
// in the output register; a sample passes the input register and then the
// output register, which drives m_tvalid. The input stage stalls only while a
// finished command waits in the output register.
// Elapsed times are 32-bit modulo differences against the sample timestamps.
`include "assert_macros.svh"

module tap_doubletap_hold_classifier
  import tdhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [39:0]      s_tdata,   // [0] button_pressed, [32:1] timestamp_ms, rest zero
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [0] direction, rest zero
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  tdhc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input stage
  logic           in_valid_q;
  logic           in_level_q;
  logic [TsW-1:0] in_ts_q;
  logic           adv;
  logic           s_xfer;

  // gesture state
  gesture_e       state_q, state_d;
  logic           prev_q;
  logic [TsW-1:0] press_q, rel_q, emit_time_q;

  // output stage
  logic           out_valid_q;
  logic           out_dir_q;

  logic           rise, fall;
  logic           hold_hit, expired, rep_hit;
  logic [TsW-1:0] press_elapsed, gap, rep_elapsed;
  logic           emit, dir, upd_press, upd_rel, upd_emit;

  assign adv      = in_valid_q & (~out_valid_q | m_tready);
  assign s_tready = ~in_valid_q | adv;
  assign s_xfer   = s_tvalid & s_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_xfer) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_level_q <= s_tdata[0];
      in_ts_q    <= s_tdata[TsW:1];
    end
  end

  assign rise = in_level_q & ~prev_q;
  assign fall = ~in_level_q & prev_q;

  assign press_elapsed = in_ts_q - press_q;
  assign gap           = in_ts_q - rel_q;
  assign rep_elapsed   = in_ts_q - emit_time_q;

  assign hold_hit = in_level_q &
                    (press_elapsed >= {{(TsW-CfgW){1'b0}}, cfg.hold_threshold_ms});
  assign expired  = gap > {{(TsW-CfgW){1'b0}}, cfg.tap_gap_ms};
  assign rep_hit  = rep_elapsed >= {{(TsW-CfgW){1'b0}}, cfg.repeat_period_ms};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FIRST_PRESS: begin
        if (hold_hit) begin
          state_d = ST_LEFT_REPEAT;
        end else if (fall) begin
          state_d = ST_WAIT_SECOND;
        end
      end
      ST_WAIT_SECOND: begin
        if (rise && !expired) begin
          state_d = ST_RIGHT_REPEAT;
        end else if (expired) begin
          state_d = in_level_q ? ST_LEFT_REPEAT : ST_IDLE;
        end
      end
      ST_LEFT_REPEAT, ST_RIGHT_REPEAT: begin
        if (!in_level_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = rise ? ST_FIRST_PRESS : ST_IDLE;
      end
    endcase
  end

  // outputs and timestamp updates
  always_comb begin
    emit      = 1'b0;
    dir       = DIR_LEFT;
    upd_press = 1'b0;
    upd_rel   = 1'b0;
    upd_emit  = 1'b0;
    case (state_q)
      ST_FIRST_PRESS: begin
        emit     = hold_hit;
        upd_emit = hold_hit;
        upd_rel  = ~hold_hit & fall;
      end
      ST_WAIT_SECOND: begin
        if (rise && !expired) begin
          emit     = 1'b1;
          dir      = DIR_RIGHT;
          upd_emit = 1'b1;
        end else if (expired) begin
          emit     = 1'b1;
          upd_emit = in_level_q;
        end
      end
      ST_LEFT_REPEAT, ST_RIGHT_REPEAT: begin
        emit     = in_level_q & rep_hit;
        upd_emit = in_level_q & rep_hit;
        dir      = (state_q == ST_RIGHT_REPEAT) ? DIR_RIGHT : DIR_LEFT;
      end
      default: begin
        upd_press = rise;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= 1'b0;
      press_q     <= '0;
      rel_q       <= '0;
      emit_time_q <= '0;
    end else if (adv) begin
      state_q <= state_d;
      prev_q  <= in_level_q;
      if (upd_press) press_q     <= in_ts_q;
      if (upd_rel)   rel_q       <= in_ts_q;
      if (upd_emit)  emit_time_q <= in_ts_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_dir_q <= dir;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {7'b0, out_dir_q};

  `ASSERT_PROP(a_out_stall_hold,
    out_valid_q && !m_tready |=> out_valid_q && $stable(out_dir_q),
    "stalled command changed")
  `ASSERT_PROP(a_repeat_held,
    (state_q == ST_LEFT_REPEAT || state_q == ST_RIGHT_REPEAT) |-> prev_q,
    "repeat state with button released")
  `ASSERT_PROP(a_first_press_held, (state_q == ST_FIRST_PRESS) |-> prev_q,
    "first press state with button released")
  `ASSERT_PROP(a_wait_released, (state_q == ST_WAIT_SECOND) |-> !prev_q,
    "wait state with button held")
  `ASSERT_PROP(a_out_from_sample, $rose(out_valid_q) |-> $past(adv),
    "output valid without a classified sample")

endmodule
